/* sv/assert_macros.svh */
// assertion helpers, compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_ON(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/cmfuv_pkg.sv */
package cmfuv_pkg;

  // fraction bits of the face coordinate, 1.0 = 2**FRAC_BITS
  localparam int unsigned FRAC_BITS = 16;
  // quotient width, holds 0 .. 2**FRAC_BITS
  localparam int unsigned COORD_W = FRAC_BITS + 1;
  // entries of the queue between classifier and divider
  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

/* sv/cmfuv_front.sv */
module cmfuv_front
  import cmfuv_pkg::*;
#(
  parameter int unsigned CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [CW-1:0] dir_x_i,
  input  logic signed [CW-1:0] dir_y_i,
  input  logic signed [CW-1:0] dir_z_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output logic [CW:0]          num_u_o,
  output logic [CW:0]          num_v_o,
  output logic [CW-1:0]        mag_o,
  output logic                 zero_o
);

  typedef enum logic [2:0] {
    FACE_POS_X,
    FACE_NEG_X,
    FACE_POS_Y,
    FACE_NEG_Y,
    FACE_POS_Z,
    FACE_NEG_Z
  } face_e;

  logic signed [CW:0] xs, ys, zs;
  logic [CW-1:0]      ax, ay, az, mag;
  logic               x_pos, y_pos, z_pos;
  face_e              face;
  logic signed [CW:0] uc, vc, mag_s, sum_u, sum_v;

  logic               valid_q;
  logic [CW:0]        num_u_q, num_v_q;
  logic [CW-1:0]      mag_q;
  logic               zero_q;
  logic               load;

  // one extra bit so the most negative value negates cleanly
  assign xs = {dir_x_i[CW-1], dir_x_i};
  assign ys = {dir_y_i[CW-1], dir_y_i};
  assign zs = {dir_z_i[CW-1], dir_z_i};

  assign ax = CW'(xs[CW] ? -xs : xs);
  assign ay = CW'(ys[CW] ? -ys : ys);
  assign az = CW'(zs[CW] ? -zs : zs);

  assign x_pos = !dir_x_i[CW-1] && (dir_x_i != '0);
  assign y_pos = !dir_y_i[CW-1] && (dir_y_i != '0);
  assign z_pos = !dir_z_i[CW-1] && (dir_z_i != '0);

  // ties go to the earlier axis
  always_comb begin
    priority if (ax >= ay && ax >= az) begin
      face = x_pos ? FACE_POS_X : FACE_NEG_X;
      mag  = ax;
    end else if (ay >= az) begin
      face = y_pos ? FACE_POS_Y : FACE_NEG_Y;
      mag  = ay;
    end else begin
      face = z_pos ? FACE_POS_Z : FACE_NEG_Z;
      mag  = az;
    end
  end

  always_comb begin
    unique case (face)
      FACE_POS_X: begin uc = -zs; vc = ys;  end
      FACE_NEG_X: begin uc = zs;  vc = ys;  end
      FACE_POS_Y: begin uc = xs;  vc = -zs; end
      FACE_NEG_Y: begin uc = xs;  vc = zs;  end
      FACE_POS_Z: begin uc = xs;  vc = ys;  end
      FACE_NEG_Z: begin uc = -xs; vc = ys;  end
      default:    begin uc = xs;  vc = ys;  end
    endcase
  end

  // uc + m lies in 0 .. 2m, fits cw+1 bits unsigned
  assign mag_s = {1'b0, mag};
  assign sum_u = uc + mag_s;
  assign sum_v = vc + mag_s;

  assign in_stall_o = valid_q && fifo_full_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      num_u_q <= sum_u;
      num_v_q <= sum_v;
      mag_q   <= mag;
      zero_q  <= (mag == '0);
    end
  end

  assign push_o  = valid_q && !fifo_full_i;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign mag_o   = mag_q;
  assign zero_o  = zero_q;

endmodule

/* sv/cmfuv_fifo.sv */
module cmfuv_fifo
  import cmfuv_pkg::*;
#(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output fifo_status_t      status_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

/* sv/cmfuv_div.sv */
module cmfuv_div
  import cmfuv_pkg::*;
#(
  parameter int unsigned CW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               pop_o,
  input  logic [CW:0]        num_u_i,
  input  logic [CW:0]        num_v_i,
  input  logic [CW-1:0]      mag_i,
  input  logic               zero_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] tex_u_o,
  output logic [COORD_W-1:0] tex_v_o,
  output logic               zero_vector_o
);

  // remainder holds 2**FRAC_BITS * num + m
  localparam int unsigned REM_W = CW + COORD_W + 1;
  localparam int unsigned LAST  = COORD_W - 1;

  logic               valid_q [COORD_W];
  logic [REM_W-1:0]   rem_u_q [COORD_W];
  logic [REM_W-1:0]   rem_v_q [COORD_W];
  logic [COORD_W-1:0] q_u_q   [COORD_W];
  logic [COORD_W-1:0] q_v_q   [COORD_W];
  logic [CW:0]        den_q   [COORD_W];
  logic               zero_q  [COORD_W];
  logic               adv;

  // whole pipe moves unless the result register is held
  assign adv   = !(valid_q[LAST] && out_stall_i);
  assign pop_o = adv && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < COORD_W; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int s = 1; s < COORD_W; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // one quotient bit per stage, msb first
  for (genvar s = 0; s < COORD_W; s++) begin : g_stage
    localparam int unsigned BIT = COORD_W - 1 - s;

    logic [REM_W-1:0]   rem_u, rem_v, sub;
    logic [COORD_W-1:0] q_u, q_v;
    logic [CW:0]        den;
    logic               zero;
    logic               take_u, take_v;

    if (s == 0) begin : g_head
      assign rem_u = REM_W'({num_u_i, FRAC_BITS'(0)}) + REM_W'(mag_i);
      assign rem_v = REM_W'({num_v_i, FRAC_BITS'(0)}) + REM_W'(mag_i);
      assign q_u   = '0;
      assign q_v   = '0;
      assign den   = {mag_i, 1'b0};
      assign zero  = zero_i;
    end else begin : g_body
      assign rem_u = rem_u_q[s-1];
      assign rem_v = rem_v_q[s-1];
      assign q_u   = q_u_q[s-1];
      assign q_v   = q_v_q[s-1];
      assign den   = den_q[s-1];
      assign zero  = zero_q[s-1];
    end

    assign sub    = REM_W'(den) << BIT;
    assign take_u = (rem_u >= sub);
    assign take_v = (rem_v >= sub);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_u_q[s] <= take_u ? rem_u - sub : rem_u;
        rem_v_q[s] <= take_v ? rem_v - sub : rem_v;
        q_u_q[s]   <= {q_u[COORD_W-2:0], take_u};
        q_v_q[s]   <= {q_v[COORD_W-2:0], take_v};
        den_q[s]   <= den;
        zero_q[s]  <= zero;
      end
    end
  end

  assign out_valid_o   = valid_q[LAST];
  assign zero_vector_o = zero_q[LAST];
  assign tex_u_o       = zero_q[LAST] ? '0 : q_u_q[LAST];
  assign tex_v_o       = zero_q[LAST] ? '0 : q_v_q[LAST];

endmodule

/* sv/cube_map_face_uv.sv */
// cube map face selection and face coordinates
//
// input channel: in_valid_i / in_stall_o carry one direction word (dir_x_i,
// dir_y_i, dir_z_i, signed two's complement of COMPONENT_WIDTH bits)
// output channel: out_valid_o / out_stall_i carry one result word (tex_u_o,
// tex_v_o in 0 .. 65536 where 65536 is 1.0, and zero_vector_o)
// a word moves on a rising edge with valid high and stall low
//
// every input word gives exactly one result word, in order
// throughput: one word per cycle while out_stall_i stays low; each word passes
// the classifier register, one queue slot and the 17-stage divider (one
// quotient bit per stage, u and v side by side) on its way to out_valid_o
//
// an all-zero direction flags zero_vector_o with both coordinates zero
// reset clears the classifier, the queue and the divider valids
// when the receiver stalls the divider holds, the two-entry queue absorbs
// words from the classifier, and in_stall_o rises only once it is full
`include "assert_macros.svh"

module cube_map_face_uv
  import cmfuv_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] dir_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_W-1:0]                tex_u_o,
  output logic [COORD_W-1:0]                tex_v_o,
  output logic                              zero_vector_o
);

  localparam int unsigned CW = COMPONENT_WIDTH;
  // queued word: num_u, num_v, magnitude, zero flag
  localparam int unsigned Q_W = 2 * (CW + 1) + CW + 1;

  logic         push, pop;
  fifo_status_t fifo_st;
  logic [CW:0]  f_num_u, f_num_v, b_num_u, b_num_v;
  logic [CW-1:0] f_mag, b_mag;
  logic         f_zero, b_zero;
  logic [Q_W-1:0] push_data, pop_data;

  // front: take the direction, pick the face, form uc + m, vc + m and m
  cmfuv_front #(
    .CW (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .fifo_full_i (fifo_st.full),
    .push_o      (push),
    .num_u_o     (f_num_u),
    .num_v_o     (f_num_v),
    .mag_o       (f_mag),
    .zero_o      (f_zero)
  );

  assign push_data = {f_num_u, f_num_v, f_mag, f_zero};

  // short queue so front and divider stall on their own
  cmfuv_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_st)
  );

  assign {b_num_u, b_num_v, b_mag, b_zero} = pop_data;

  // back: pipelined restoring divide, rounded to nearest
  cmfuv_div #(
    .CW (CW)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (!fifo_st.empty),
    .pop_o         (pop),
    .num_u_i       (b_num_u),
    .num_v_i       (b_num_v),
    .mag_i         (b_mag),
    .zero_i        (b_zero),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .zero_vector_o (zero_vector_o)
  );

  // coordinates never pass 1.0
  `ASSERT_ON(a_coord_range, clk_i, rst_ni, out_valid_o |-> (tex_u_o <= COORD_W'(1 << FRAC_BITS)) && (tex_v_o <= COORD_W'(1 << FRAC_BITS)), "face coordinate above 1.0")

  // a zero vector comes out with both coordinates cleared
  `ASSERT_ON(a_zero_coords, clk_i, rst_ni, (out_valid_o && zero_vector_o) |-> (tex_u_o == '0) && (tex_v_o == '0), "zero vector with nonzero coordinates")

  // queue status is consistent outside reset
  `ASSERT_ON(a_fifo_status, clk_i, rst_ni, !(fifo_st.full && fifo_st.empty), "queue full and empty at once")

  // input stalls only while the divider is held by the receiver, or as that hold ends
  `ASSERT_ON(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i) || $past(out_valid_o && out_stall_i), "input stalled with the output free")

endmodule

/* tb/tb.sv */
module tb;
  import cmfuv_pkg::*;

  // component width of the block under test
  localparam int unsigned CW = 16;
  // cycles with no word moving on either side before the run is called hung
  localparam int unsigned HANG_LIMIT = 4000;
  // settle time after the last result, well over the pipeline depth
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 600;
  // word counts at which the pressure phases kick in and end, and the long hold's length
  localparam int unsigned HOLD_AT = 150;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned DRAIN_PAUSE_AT = 260;
  localparam int unsigned QUIET_FROM = 350;
  localparam int unsigned QUIET_TO = 450;

  typedef logic signed [CW-1:0] comp_t;

  // one result word as the block presents it
  typedef struct packed {
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic               zero;
  } face_word_t;

  // one row of the directed table, with a typed-in answer where it is obvious
  typedef struct {
    comp_t      x;
    comp_t      y;
    comp_t      z;
    bit         typed;
    face_word_t want;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  comp_t              dir_x_i = '0;
  comp_t              dir_y_i = '0;
  comp_t              dir_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [COORD_W-1:0] tex_u_o;
  logic [COORD_W-1:0] tex_v_o;
  logic               zero_vector_o;

  // expected face coordinates, oldest first
  face_word_t pending_uv[$];
  dir_row_t   dir_rows[$];
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  cube_map_face_uv #(
    .COMPONENT_WIDTH(CW)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tex_u_o      (tex_u_o),
    .tex_v_o      (tex_v_o),
    .zero_vector_o(zero_vector_o)
  );

  always #5 clk_i = ~clk_i;

  // (c/m + 1)/2 scaled to 65536, rounded to nearest with halves up
  function automatic logic [COORD_W-1:0] face_coord(longint c, longint m);
    longint q;
    q = ((c + m) * 65536 + m) / (2 * m);
    return q[COORD_W-1:0];
  endfunction

  // face pick and face coordinates for one direction
  function automatic face_word_t face_uv(comp_t x, comp_t y, comp_t z);
    longint sx, sy, sz, ax, ay, az, m, uc, vc;
    face_word_t w;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    // all-zero direction has no face, coordinates forced to zero
    if (ax == 0 && ay == 0 && az == 0) begin
      w.u = '0;
      w.v = '0;
      w.zero = 1'b1;
      return w;
    end
    // ties go to the earlier axis: x over y and z, y over z
    if (ax >= ay && ax >= az) begin
      m = ax;
      uc = (sx > 0) ? -sz : sz;
      vc = sy;
    end else if (ay >= az) begin
      m = ay;
      uc = sx;
      vc = (sy > 0) ? -sz : sz;
    end else begin
      m = az;
      uc = (sz > 0) ? sx : -sx;
      vc = sy;
    end
    w.u = face_coord(uc, m);
    w.v = face_coord(vc, m);
    w.zero = 1'b0;
    return w;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // window where both sides run flat out
  function automatic bit quiet_window();
    return words_sent >= QUIET_FROM && words_sent < QUIET_TO;
  endfunction

  function automatic int signed_mag(int a);
    return $urandom_range(0, 1) ? a : -a;
  endfunction

  task automatic add_row(int x, int y, int z, bit typed, int u, int v, bit zero);
    dir_row_t r;
    r.x = comp_t'(x);
    r.y = comp_t'(y);
    r.z = comp_t'(z);
    r.typed = typed;
    r.want.u = COORD_W'(u);
    r.want.v = COORD_W'(v);
    r.want.zero = zero;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // random direction, weighted toward faces, ties and extremes
  task automatic pick_dir(output comp_t x, output comp_t y, output comp_t z);
    int c[3];
    int unsigned r, k;
    int a;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 2);
    if (r < 40) begin
      // raw bits, every bit of every field toggles
      c[0] = $urandom;
      c[1] = $urandom;
      c[2] = $urandom;
    end else if (r < 60) begin
      // one clear winner on a random axis
      a = $urandom_range(1, 32768);
      c[k] = (a == 32768) ? -32768 : signed_mag(a);
      c[(k + 1) % 3] = int'($urandom_range(0, 2 * (a - 1))) - (a - 1);
      c[(k + 2) % 3] = int'($urandom_range(0, 2 * (a - 1))) - (a - 1);
    end else if (r < 75) begin
      // two axes tie, third no larger
      a = $urandom_range(1, 32767);
      c[k] = signed_mag(a);
      c[(k + 1) % 3] = signed_mag(a);
      c[(k + 2) % 3] = int'($urandom_range(0, 2 * a)) - a;
    end else if (r < 85) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 7))
          0: c[i] = -32768;
          1: c[i] = -32767;
          2: c[i] = -1;
          3: c[i] = 0;
          4: c[i] = 1;
          5: c[i] = 32767;
          6: c[i] = 16384;
          default: c[i] = -16384;
        endcase
      end
    end else if (r < 95) begin
      // tiny magnitudes, coarse ratios and many ties
      for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 6)) - 3;
    end else begin
      c[0] = 0;
      c[1] = 0;
      c[2] = 0;
    end
    x = comp_t'(c[0]);
    y = comp_t'(c[1]);
    z = comp_t'(c[2]);
  endtask

  // offer one direction word, hold it until taken, then maybe go idle
  task automatic send_dir(comp_t x, comp_t y, comp_t z, bit typed, face_word_t want);
    int unsigned gap;
    in_valid_i <= 1'b1;
    dir_x_i <= x;
    dir_y_i <= y;
    dir_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_uv.insert(pending_uv.size(), typed ? want : face_uv(x, y, z));
    words_sent++;
    gap = quiet_window() ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what, face_word_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): want u=%0d v=%0d zero=%0d, got u=%0d v=%0d zero=%0d",
               what, want.u, want.v, want.zero, tex_u_o, tex_v_o, zero_vector_o);
    end
  endtask

  // directed table: zero vector, extremes, every face, ties, most negative values
  initial begin
    add_row(0, 0, 0, 1, 0, 0, 1);
    add_row(16384, 0, 0, 1, 32768, 32768, 0);
    add_row(32767, 32767, 32767, 1, 0, 65536, 0);
    add_row(-32768, -32768, -32768, 1, 0, 0, 0);
    add_row(1, 0, 0, 1, 32768, 32768, 0);
    add_row(-16384, 0, 0, 0, 0, 0, 0);
    add_row(0, 16384, 0, 0, 0, 0, 0);
    add_row(0, -16384, 0, 0, 0, 0, 0);
    add_row(0, 0, 16384, 0, 0, 0, 0);
    add_row(0, 0, -16384, 0, 0, 0, 0);
    add_row(-32768, 32767, 0, 0, 0, 0, 0);
    add_row(100, -100, 50, 0, 0, 0, 0);
    add_row(0, 200, -200, 0, 0, 0, 0);
    add_row(-300, 5, 300, 0, 0, 0, 0);
    add_row(32767, -32768, 0, 0, 0, 0, 0);
    add_row(0, 0, -32768, 0, 0, 0, 0);
    add_row(3, 1, -2, 0, 0, 0, 0);
    add_row(-1, -1, 0, 0, 0, 0, 0);
    add_row(0, -1, 1, 0, 0, 0, 0);
    add_row(20000, -20000, -20000, 0, 0, 0, 0);
    add_row(-32768, 32767, -32767, 0, 0, 0, 0);
    add_row(12345, -32767, 32767, 0, 0, 0, 0);
  end

  // sender: directed table, then random words
  initial begin : drive_dirs
    comp_t x, y, z;
    face_word_t none;
    none = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_dir(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
               dir_rows[i].want);
    end
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // once, stop offering until the pipeline has drained completely
      if (words_sent == DRAIN_PAUSE_AT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_uv.size() != 0) @(posedge clk_i);
      end
      pick_dir(x, y, z);
      send_dir(x, y, z, 1'b0, none);
    end
    in_valid_i <= 1'b0;
    while (pending_uv.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_uv.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold so the input side backs up
  initial begin : drive_stall
    bit held;
    int unsigned n;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && words_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = quiet_window() ? 0 : idle_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // result check against the oldest expectation, plus the hang watchdog
  always @(posedge clk_i) begin : check_words
    face_word_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_uv.size() == 0) begin
          want = '0;
          report_mismatch("result with nothing expected", want);
        end else begin
          want = pending_uv.pop_front();
          // field by field, so a wrong flag is caught even with zero coordinates
          if (tex_u_o !== want.u || tex_v_o !== want.v || zero_vector_o !== want.zero) begin
            report_mismatch("face word", want);
          end
        end
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
+incdir+sv
sv/cmfuv_pkg.sv
sv/cmfuv_front.sv
sv/cmfuv_fifo.sv
sv/cmfuv_div.sv
sv/cube_map_face_uv.sv
tb/tb.sv
